FILE: rtl/core/bgu_pkg.sv
package bgu_pkg;

    // Sizing of the source store, destination grid and sample width.
    localparam int MAX_SRC_DIM = 256;
    localparam int MAX_DST_DIM = 16384;
    localparam int SAMPLE_BITS = 16;

    // Fixed field widths of the stream and register interfaces.
    localparam int COORD_W        = 14;
    localparam int SAMPLE_FIELD_W = 16;
    localparam int SRC_CFG_W      = 9;
    localparam int DST_CFG_W      = 15;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 16;
    localparam int COL_LSB        = 0;
    localparam int ROW_LSB        = COL_LSB + COORD_W;
    localparam int SAMPLE_LSB     = ROW_LSB + COORD_W;

    // Datapath widths derived from the sizing constants.
    localparam int SIDX_W      = $clog2(MAX_SRC_DIM);
    localparam int ADDR_W      = 2 * SIDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DX_W        = $clog2(MAX_DST_DIM);
    localparam int H_W         = SAMPLE_BITS + DX_W;
    localparam int P_W         = H_W + DX_W;
    localparam int DEN_W       = 2 * DX_W;
    localparam int NUM_W       = P_W + 1;
    localparam int DSH_W       = DEN_W + SAMPLE_BITS;
    localparam int CNT_W       = $clog2(SAMPLE_BITS + 1);

    localparam int BYTE_LIMIT = 255;

    // Register port.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_SRC_WIDTH  = reg_idx_t'(0);
    localparam reg_idx_t REG_SRC_HEIGHT = reg_idx_t'(1);
    localparam reg_idx_t REG_DST_WIDTH  = reg_idx_t'(2);
    localparam reg_idx_t REG_DST_HEIGHT = reg_idx_t'(3);
    localparam reg_idx_t REG_BYTE_MODE  = reg_idx_t'(4);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Effective (clamped) configuration seen by the datapath.
    typedef struct packed {
        logic [SRC_CFG_W-1:0] sw;
        logic [SRC_CFG_W-1:0] sh;
        logic [DX_W-1:0]      dx;
        logic [DX_W-1:0]      dy;
        logic                 byte_mode;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/core/bgu_regs.sv
module bgu_regs import bgu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [SRC_CFG_W-1:0] src_width_reg;
    logic [SRC_CFG_W-1:0] src_height_reg;
    logic [DST_CFG_W-1:0] dst_width_reg;
    logic [DST_CFG_W-1:0] dst_height_reg;
    logic                 byte_mode_reg;
    reg_idx_t             idx;
    logic                 wr_en;
    logic [DST_CFG_W-1:0] dw_eff;
    logic [DST_CFG_W-1:0] dh_eff;

    function automatic logic [SRC_CFG_W-1:0] clamp_src(input logic [SRC_CFG_W-1:0] v);
        logic [SRC_CFG_W-1:0] r;
        if (v < SRC_CFG_W'(2)) begin
            r = SRC_CFG_W'(2);
        end else if (v > SRC_CFG_W'(MAX_SRC_DIM)) begin
            r = SRC_CFG_W'(MAX_SRC_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DST_CFG_W-1:0] clamp_dst(input logic [DST_CFG_W-1:0] v);
        logic [DST_CFG_W-1:0] r;
        if (v < DST_CFG_W'(2)) begin
            r = DST_CFG_W'(2);
        end else if (v > DST_CFG_W'(MAX_DST_DIM)) begin
            r = DST_CFG_W'(MAX_DST_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SRC_CFG_W'(2);
            src_height_reg <= SRC_CFG_W'(2);
            dst_width_reg  <= DST_CFG_W'(2);
            dst_height_reg <= DST_CFG_W'(2);
            byte_mode_reg  <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[SRC_CFG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[SRC_CFG_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DST_CFG_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DST_CFG_W-1:0];
                REG_BYTE_MODE:  byte_mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_reg);
            REG_BYTE_MODE:  prdata = PDATA_W'(byte_mode_reg);
            default:        prdata = '0;
        endcase
    end

    // The datapath works on clamped sizes and on the last index of each
    // destination axis, which is also the mapping denominator.
    assign dw_eff        = clamp_dst(dst_width_reg);
    assign dh_eff        = clamp_dst(dst_height_reg);
    assign cfg.sw        = clamp_src(src_width_reg);
    assign cfg.sh        = clamp_src(src_height_reg);
    assign cfg.dx        = DX_W'(dw_eff - DST_CFG_W'(1));
    assign cfg.dy        = DX_W'(dh_eff - DST_CFG_W'(1));
    assign cfg.byte_mode = byte_mode_reg;

endmodule

FILE: rtl/core/bgu_store.sv
module bgu_store import bgu_pkg::*; (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [0:STORE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bgu_div.sv
module bgu_div import bgu_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  div_req_t               req,
    input  logic [NUM_W-1:0]       num,
    input  logic [DSH_W-1:0]       dsh,
    output div_stat_t              stat,
    output logic [SAMPLE_BITS-1:0] quo,
    output logic [DX_W-1:0]        rem
);

    // Restoring divider, one quotient bit per cycle. The divisor arrives
    // pre-shifted left by (steps-1) and walks right one place per step.
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0]       rem_reg;
    logic [DSH_W-1:0]       dsh_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [NUM_W:0]         diff;
    logic                   fits;

    assign diff = {1'b0, rem_reg} - (NUM_W + 1)'(dsh_reg);
    assign fits = !diff[NUM_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= num;
            dsh_reg <= dsh;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= diff[NUM_W-1:0];
            end
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg[DX_W-1:0];

endmodule

FILE: rtl/core/bilinear_grid_upscaler.sv
// Load beats: the sample is written to the source store at the accept edge if it lies in the source grid.
// Compute beats raise m_tvalid after 32 serial divider steps (8 per axis mapping, 16 for
// the final normalization), 9 blend steps and the sequencing states.
// An out-of-range compute beat skips the datapath and goes straight to its error result.
// The input stalls while a compute beat runs; a new beat is taken while a result waits.
// aresetn is synchronous, active low; it clears control and config, not the source store.
module bilinear_grid_upscaler import bgu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [13:0] col, [27:14] row, [43:28] sample, rest 0
    input  logic                 s_tuser,  // [0] cmd: 0 load, 1 compute
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [15:0] out_value
    output logic                 m_tuser,  // [0] range_error
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // Sequencer. A compute beat first maps the column, then the row, each
    // as one multiply on the shared multiplier and one serial division.
    // The blend phase then reads the four neighbors and runs them through
    // the same multiplier, and a last division normalizes and rounds.
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MULX  = 11'b00000000010,
        ST_DIVX  = 11'b00000000100,
        ST_WAITX = 11'b00000001000,
        ST_MULY  = 11'b00000010000,
        ST_DIVY  = 11'b00000100000,
        ST_WAITY = 11'b00001000000,
        ST_BLEND = 11'b00010000000,
        ST_WAITF = 11'b00100000000,
        ST_OUT   = 11'b01000000000,
        ST_SPARE = 11'b10000000000
    } state_t;

    // Blend steps. The first four steps issue the store reads. A step
    // multiplies the data read (later the partial sums) from the step before
    // and accumulates the product from the step before that.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] BS_RD_00   = STEP_W'(0);
    localparam logic [STEP_W-1:0] BS_RD_10   = STEP_W'(1);
    localparam logic [STEP_W-1:0] BS_RD_01   = STEP_W'(2);
    localparam logic [STEP_W-1:0] BS_RD_11   = STEP_W'(3);
    localparam logic [STEP_W-1:0] BS_MUL_11  = STEP_W'(4);
    localparam logic [STEP_W-1:0] BS_MUL_Y0  = STEP_W'(5);
    localparam logic [STEP_W-1:0] BS_MUL_Y1  = STEP_W'(6);
    localparam logic [STEP_W-1:0] BS_MUL_DEN = STEP_W'(7);
    localparam logic [STEP_W-1:0] BS_DIV     = STEP_W'(8);

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    cfg_t                   cfg;

    logic                   in_accept;
    logic [COORD_W-1:0]     in_col;
    logic [COORD_W-1:0]     in_row;
    logic [SAMPLE_FIELD_W-1:0] in_sample;
    logic                   in_compute;
    logic                   out_range;
    logic                   load_hit;

    logic [SIDX_W-1:0]      sw_m1, sh_m1, sw_m2, sh_m2;
    logic [COORD_W-1:0]     sw_ext, sh_ext;

    logic [COORD_W-1:0]     col_reg, row_reg;
    logic [SIDX_W-1:0]      x0_reg, y0_reg;
    logic [DX_W-1:0]        rx_reg, ry_reg;
    logic [DX_W-1:0]        wx0, wy0;
    logic [SIDX_W-1:0]      x1, y1;

    logic [H_W-1:0]         mul_a;
    logic [DX_W-1:0]        mul_b;
    logic [P_W-1:0]         prod_reg;
    logic [H_W-1:0]         h_acc_reg, h0_reg;
    logic [P_W-1:0]         sum_reg;
    logic [DEN_W-1:0]       den;

    logic [ADDR_W-1:0]      raddr;
    logic [SAMPLE_BITS-1:0] rdata;

    div_req_t               div_req;
    div_stat_t              div_stat;
    logic [NUM_W-1:0]       div_num;
    logic [DSH_W-1:0]       div_dsh;
    logic [SAMPLE_BITS-1:0] div_quo;
    logic [DX_W-1:0]        div_rem;
    logic [SIDX_W-1:0]      div_q_axis;
    logic [SAMPLE_BITS-1:0] sat_value;

    logic [SAMPLE_BITS-1:0] res_value_reg;
    logic                   res_err_reg;
    logic [SAMPLE_BITS-1:0] m_value_reg;
    logic                   m_err_reg;
    logic                   out_free;

    bgu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input beat decode. Loads are written straight into the store at the
    // accept edge; a load outside the configured source grid is dropped.
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign in_col     = s_tdata[COL_LSB +: COORD_W];
    assign in_row     = s_tdata[ROW_LSB +: COORD_W];
    assign in_sample  = s_tdata[SAMPLE_LSB +: SAMPLE_FIELD_W];
    assign in_compute = (s_tuser == CMD_COMPUTE);

    assign sw_ext    = COORD_W'(cfg.sw);
    assign sh_ext    = COORD_W'(cfg.sh);
    assign load_hit  = in_accept && (s_tuser == CMD_LOAD) && (in_col < sw_ext) && (in_row < sh_ext);
    assign out_range = (in_col > cfg.dx) || (in_row > cfg.dy);

    // The highest base cell is size-2; the highest neighbor index size-1.
    assign sw_m1 = SIDX_W'(cfg.sw - SRC_CFG_W'(1));
    assign sh_m1 = SIDX_W'(cfg.sh - SRC_CFG_W'(1));
    assign sw_m2 = SIDX_W'(cfg.sw - SRC_CFG_W'(2));
    assign sh_m2 = SIDX_W'(cfg.sh - SRC_CFG_W'(2));

    // Interpolation weights. The fraction along each axis is rx/dx, so
    // the near neighbor weighs dx-rx and the far one rx.
    assign wx0 = cfg.dx - rx_reg;
    assign wy0 = cfg.dy - ry_reg;
    assign x1  = x0_reg + SIDX_W'(1);
    assign y1  = y0_reg + SIDX_W'(1);

    always_comb begin
        raddr = {y0_reg, x0_reg};
        case (step_reg)
            BS_RD_10: raddr = {y0_reg, x1};
            BS_RD_01: raddr = {y1, x0_reg};
            BS_RD_11: raddr = {y1, x1};
            default:  raddr = {y0_reg, x0_reg};
        endcase
    end

    bgu_store u_store (
        .aclk  (aclk),
        .we    (load_hit),
        .waddr ({in_row[SIDX_W-1:0], in_col[SIDX_W-1:0]}),
        .wdata (in_sample[SAMPLE_BITS-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MULX: begin
                mul_a = H_W'(col_reg);
                mul_b = DX_W'(sw_m1);
            end
            ST_MULY: begin
                mul_a = H_W'(row_reg);
                mul_b = DX_W'(sh_m1);
            end
            ST_BLEND: begin
                case (step_reg)
                    BS_RD_10: begin
                        mul_a = H_W'(rdata);
                        mul_b = wx0;
                    end
                    BS_RD_01: begin
                        mul_a = H_W'(rdata);
                        mul_b = rx_reg;
                    end
                    BS_RD_11: begin
                        mul_a = H_W'(rdata);
                        mul_b = wx0;
                    end
                    BS_MUL_11: begin
                        mul_a = H_W'(rdata);
                        mul_b = rx_reg;
                    end
                    BS_MUL_Y0: begin
                        mul_a = h0_reg;
                        mul_b = wy0;
                    end
                    BS_MUL_Y1: begin
                        mul_a = h_acc_reg;
                        mul_b = ry_reg;
                    end
                    BS_MUL_DEN: begin
                        mul_a = H_W'(cfg.dx);
                        mul_b = cfg.dy;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Divider requests. An axis mapping divides col*(size-1) by dx, or
    // row*(size-1) by dy, and needs eight quotient bits. The final division
    // computes (2*sum + den) / (2*den), which is the blend rounded half up.
    assign den = prod_reg[DEN_W-1:0];

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = CNT_W'(SIDX_W);
        div_num       = NUM_W'(prod_reg);
        div_dsh       = DSH_W'(cfg.dx) << (SIDX_W - 1);
        case (state_reg)
            ST_DIVX: begin
                div_req.start = 1'b1;
            end
            ST_DIVY: begin
                div_req.start = 1'b1;
                div_dsh       = DSH_W'(cfg.dy) << (SIDX_W - 1);
            end
            ST_BLEND: begin
                if (step_reg == BS_DIV) begin
                    div_req.start = 1'b1;
                    div_req.steps = CNT_W'(SAMPLE_BITS);
                    div_num       = {sum_reg, 1'b0} + NUM_W'(den);
                    div_dsh       = {den, {SAMPLE_BITS{1'b0}}};
                end
            end
            default: ;
        endcase
    end

    bgu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .dsh     (div_dsh),
        .stat    (div_stat),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign div_q_axis = div_quo[SIDX_W-1:0];
    assign sat_value  = (cfg.byte_mode && (div_quo > SAMPLE_BITS'(BYTE_LIMIT)))
                        ? SAMPLE_BITS'(BYTE_LIMIT) : div_quo;

    assign out_free = !m_tvalid_reg || m_tready;

    // Control path.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_compute) begin
                    state_next = out_range ? ST_OUT : ST_MULX;
                end
            end
            ST_MULX:  state_next = ST_DIVX;
            ST_DIVX:  state_next = ST_WAITX;
            ST_WAITX: begin
                if (div_stat.done) begin
                    state_next = ST_MULY;
                end
            end
            ST_MULY:  state_next = ST_DIVY;
            ST_DIVY:  state_next = ST_WAITY;
            ST_WAITY: begin
                if (div_stat.done) begin
                    state_next = ST_BLEND;
                    step_next  = BS_RD_00;
                end
            end
            ST_BLEND: begin
                if (step_reg == BS_DIV) begin
                    state_next = ST_WAITF;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_WAITF: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= BS_RD_00;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= P_W'(mul_a) * P_W'(mul_b);

        if (in_accept) begin
            col_reg <= in_col;
            row_reg <= in_row;
        end

        if ((state_reg == ST_IDLE) && in_accept && in_compute && out_range) begin
            res_value_reg <= '0;
            res_err_reg   <= 1'b1;
        end

        // The last column or row maps past the last base cell; hold the
        // base at size-2 and give the far neighbor full weight.
        if ((state_reg == ST_WAITX) && div_stat.done) begin
            if (div_q_axis > sw_m2) begin
                x0_reg <= sw_m2;
                rx_reg <= div_rem + cfg.dx;
            end else begin
                x0_reg <= div_q_axis;
                rx_reg <= div_rem;
            end
        end

        if ((state_reg == ST_WAITY) && div_stat.done) begin
            if (div_q_axis > sh_m2) begin
                y0_reg <= sh_m2;
                ry_reg <= div_rem + cfg.dy;
            end else begin
                y0_reg <= div_q_axis;
                ry_reg <= div_rem;
            end
        end

        if (state_reg == ST_BLEND) begin
            case (step_reg)
                BS_RD_01:   h_acc_reg <= H_W'(prod_reg);
                BS_RD_11:   h_acc_reg <= h_acc_reg + H_W'(prod_reg);
                BS_MUL_11: begin
                    h0_reg    <= h_acc_reg;
                    h_acc_reg <= H_W'(prod_reg);
                end
                BS_MUL_Y0:  h_acc_reg <= h_acc_reg + H_W'(prod_reg);
                BS_MUL_Y1:  sum_reg   <= prod_reg;
                BS_MUL_DEN: sum_reg   <= sum_reg + prod_reg;
                default: ;
            endcase
        end

        if ((state_reg == ST_WAITF) && div_stat.done) begin
            res_value_reg <= sat_value;
            res_err_reg   <= 1'b0;
        end

        if ((state_reg == ST_OUT) && out_free) begin
            m_value_reg <= res_value_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_value_reg);
    assign m_tuser  = m_err_reg;

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_base_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLEND) |-> ((x0_reg <= sw_m2) && (y0_reg <= sh_m2)))
        else $error("base cell outside source grid");

    a_frac_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLEND) |-> ((rx_reg <= cfg.dx) && (ry_reg <= cfg.dy)))
        else $error("interpolation fraction above one");

    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("range error result carries a nonzero value");

    a_byte_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && !res_err_reg && cfg.byte_mode)
            |-> (res_value_reg <= SAMPLE_BITS'(BYTE_LIMIT)))
        else $error("byte mode result above byte limit");

endmodule

FILE: tb/sv/bilinear_grid_upscaler_checker.sv
module bilinear_grid_upscaler_checker import bgu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic                      range_error;
        logic [SAMPLE_FIELD_W-1:0] out_value;
    } point_result_t;

    logic [SAMPLE_BITS-1:0] sample_grid [STORE_DEPTH];
    logic [SRC_CFG_W-1:0]   src_width_q  = SRC_CFG_W'(2);
    logic [SRC_CFG_W-1:0]   src_height_q = SRC_CFG_W'(2);
    logic [DST_CFG_W-1:0]   dst_width_q  = DST_CFG_W'(2);
    logic [DST_CFG_W-1:0]   dst_height_q = DST_CFG_W'(2);
    logic                   byte_mode_q  = 1'b0;
    point_result_t          expected_points [$];
    int                     error_count = 0;

    function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned grid_at(longint unsigned x, longint unsigned y);
        return longint'(sample_grid[y * MAX_SRC_DIM + x]);
    endfunction

    // Corner-aligned mapping kept as an exact quotient and remainder over
    // the destination span, then a rational blend of the four neighbours.
    function automatic point_result_t interpolate_point(longint unsigned col,
                                                        longint unsigned row);
        point_result_t res;
        longint unsigned sw, sh, dw, dh, dx, dy, qx, qy, rx, ry, sum, den, val, lim;
        sw = clamp_dim(src_width_q, MAX_SRC_DIM);
        sh = clamp_dim(src_height_q, MAX_SRC_DIM);
        dw = clamp_dim(dst_width_q, MAX_DST_DIM);
        dh = clamp_dim(dst_height_q, MAX_DST_DIM);
        res = '0;
        if (col >= dw || row >= dh) begin
            res.range_error = 1'b1;
            return res;
        end
        dx = dw - 1;
        dy = dh - 1;
        qx = (col * (sw - 1)) / dx;
        rx = (col * (sw - 1)) % dx;
        qy = (row * (sh - 1)) / dy;
        ry = (row * (sh - 1)) % dy;
        // On the last column or row the base cell stays one short of the edge
        // and the far neighbour carries the full weight.
        if (qx > sw - 2) begin
            rx = rx + (qx - (sw - 2)) * dx;
            qx = sw - 2;
        end
        if (qy > sh - 2) begin
            ry = ry + (qy - (sh - 2)) * dy;
            qy = sh - 2;
        end
        sum = grid_at(qx, qy) * (dx - rx) * (dy - ry)
            + grid_at(qx + 1, qy) * rx * (dy - ry)
            + grid_at(qx, qy + 1) * (dx - rx) * ry
            + grid_at(qx + 1, qy + 1) * rx * ry;
        den = dx * dy;
        val = (2 * sum + den) / (2 * den);
        lim = byte_mode_q ? BYTE_LIMIT : (64'd1 << SAMPLE_BITS) - 1;
        if (val > lim) val = lim;
        res.out_value = SAMPLE_FIELD_W'(val);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        point_result_t      got;
        point_result_t      want;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        if (!aresetn) begin
            src_width_q  <= SRC_CFG_W'(2);
            src_height_q <= SRC_CFG_W'(2);
            dst_width_q  <= DST_CFG_W'(2);
            dst_height_q <= DST_CFG_W'(2);
            byte_mode_q  <= 1'b0;
            expected_points.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_CFG_W-1:0];
                    REG_SRC_HEIGHT: src_height_q <= pwdata[SRC_CFG_W-1:0];
                    REG_DST_WIDTH:  dst_width_q  <= pwdata[DST_CFG_W-1:0];
                    REG_DST_HEIGHT: dst_height_q <= pwdata[DST_CFG_W-1:0];
                    REG_BYTE_MODE:  byte_mode_q  <= pwdata[0];
                    default: ;
                endcase
            end
            // Results are matched before new inputs are queued, so a result can
            // never be paired with the compute beat taken at the same edge.
            if (m_tvalid && m_tready) begin
                got.range_error = m_tuser;
                got.out_value   = m_tdata[SAMPLE_FIELD_W-1:0];
                if (expected_points.size() == 0) begin
                    $display("%0t: result beat with nothing pending: out_value %0d range_error %0d",
                             $time, got.out_value, got.range_error);
                    error_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.out_value !== want.out_value) begin
                        $display("%0t: out_value expected %0d, got %0d",
                                 $time, want.out_value, got.out_value);
                        error_count++;
                    end
                    if (got.range_error !== want.range_error) begin
                        $display("%0t: range_error expected %0d, got %0d",
                                 $time, want.range_error, got.range_error);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                col = s_tdata[COL_LSB +: COORD_W];
                row = s_tdata[ROW_LSB +: COORD_W];
                if (s_tuser == CMD_LOAD) begin
                    if (col < clamp_dim(src_width_q, MAX_SRC_DIM) &&
                        row < clamp_dim(src_height_q, MAX_SRC_DIM))
                        sample_grid[int'(row) * MAX_SRC_DIM + int'(col)] =
                            s_tdata[SAMPLE_LSB +: SAMPLE_BITS];
                end else begin
                    expected_points.push_back(interpolate_point(col, row));
                end
            end
        end
        mismatches  <= error_count;
        outstanding <= expected_points.size();
    end

endmodule

FILE: tb/sv/bilinear_grid_upscaler_test.sv
// Stimulus and verdict for the bilinear grid upscaler. The checker instance
// beside the block predicts every result; this module only builds traffic,
// keeps track of which source cells hold a sample, and decides pass or fail.
module bilinear_grid_upscaler_test import bgu_pkg::*;;

    // Cycles allowed after the last result before a register write or the verdict.
    localparam int DRAIN_CYCLES   = 64;
    // The longest legal stretch without any accepted beat (drain pause, one
    // compute, both sides stalling) stays far below this limit, so it only
    // fires on a hang.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 19;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // [13:0] col, [27:14] row, [43:28] sample, rest 0
    logic                 s_tuser  = 1'b0; // [0] cmd: 0 load, 1 compute
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [15:0] out_value
    logic                 m_tuser;         // [0] range_error
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int mismatches;
    int outstanding;

    // Raw register values as last written; the block clamps them on use.
    int cfg_sw = 2;
    int cfg_sh = 2;
    int cfg_dw = 2;
    int cfg_dh = 2;

    // Source cells that hold a sample. The store is undefined until written,
    // so no compute may ever touch a cell that is not marked here.
    bit cell_loaded [STORE_DEPTH];

    // When set, neither side idles: gives stretches of back-to-back beats.
    bit quiet = 1'b0;

    int stall_left  = 0;
    int next_stall  = 0;
    int idle_cycles = 0;

    bilinear_grid_upscaler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bilinear_grid_upscaler_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver draws a fresh stall after every result beat it takes, so
    // the stall may start before or after the next result shows up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            next_stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            stall_left <= next_stall;
            m_tready   <= (next_stall == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    // Lower source cell of the pair that a destination coordinate falls in, on either axis.
    function automatic int base_cell(int d, int sdim, int ddim);
        int q;
        q = (d * (sdim - 1)) / (ddim - 1);
        return (q > sdim - 2) ? sdim - 2 : q;
    endfunction

    // Random coordinate inside a dimension, with 0 and dim-1 favored.
    function automatic int pick_coord(int dim);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 0;
        if (pick == 1) return dim - 1;
        return $urandom_range(0, dim - 1);
    endfunction

    // One input beat. The valid is only lowered when a gap is drawn, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    task automatic send_beat(input logic cmd, input int col, input int row, input int sample);
        logic [S_TDATA_W-1:0] beat;
        int                   gap;
        beat = '0;
        beat[COL_LSB +: COORD_W]           = COORD_W'(col);
        beat[ROW_LSB +: COORD_W]           = COORD_W'(row);
        beat[SAMPLE_LSB +: SAMPLE_FIELD_W] = SAMPLE_FIELD_W'(sample);
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_at(input int col, input int row, input int sample);
        send_beat(CMD_LOAD, col, row, sample);
        if (col < clamp_dim(cfg_sw, MAX_SRC_DIM) && row < clamp_dim(cfg_sh, MAX_SRC_DIM))
            cell_loaded[row * MAX_SRC_DIM + col] = 1'b1;
    endtask

    // A compute beat inside the grid is preceded by loads of any of its four
    // neighbours that were never written.
    task automatic compute_at(input int col, input int row);
        int sw, sh, dw, dh, x0, y0;
        sw = clamp_dim(cfg_sw, MAX_SRC_DIM);
        sh = clamp_dim(cfg_sh, MAX_SRC_DIM);
        dw = clamp_dim(cfg_dw, MAX_DST_DIM);
        dh = clamp_dim(cfg_dh, MAX_DST_DIM);
        if (col < dw && row < dh) begin
            x0 = base_cell(col, sw, dw);
            y0 = base_cell(row, sh, dh);
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 2; i++) begin
                    if (!cell_loaded[(y0 + j) * MAX_SRC_DIM + x0 + i])
                        load_at(x0 + i, y0 + j, $urandom_range(0, 65535));
                end
            end
        end
        send_beat(CMD_COMPUTE, col, row, $urandom_range(0, 65535));
    endtask

    // Stops the sender until every pending result has been taken.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Register writes happen only with the block idle: all results in, then
    // a pause long enough for a last load to finish.
    task automatic settle();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge where
    // pready is seen high. Bits 31:16 are random junk outside every register.
    task automatic write_reg(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value) | ($urandom() & 32'hFFFF_0000);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int sw, input int sh, input int dw, input int dh,
                                 input int bm);
        settle();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_BYTE_MODE, bm);
        cfg_sw = sw;
        cfg_sh = sh;
        cfg_dw = dw;
        cfg_dh = dh;
    endtask

    // Mostly well-formed computes inside the grid, some loads over the
    // source area, and a share of noise across the full field ranges.
    task automatic random_phase(input int ops, input int pause_at);
        int sw, sh, dw, dh, pick;
        sw = clamp_dim(cfg_sw, MAX_SRC_DIM);
        sh = clamp_dim(cfg_sh, MAX_SRC_DIM);
        dw = clamp_dim(cfg_dw, MAX_DST_DIM);
        dh = clamp_dim(cfg_dh, MAX_DST_DIM);
        for (int op = 0; op < ops; op++) begin
            if (op == pause_at) wait_results_drained();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                compute_at(pick_coord(dw), pick_coord(dh));
            end else if (pick < 85) begin
                load_at(pick_coord(sw), pick_coord(sh), $urandom_range(0, 65535));
            end else if (pick < 93) begin
                compute_at($urandom_range(0, 16383), $urandom_range(0, 16383));
            end else begin
                load_at($urandom_range(0, 16383), $urandom_range(0, 16383),
                        $urandom_range(0, 65535));
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset setting (2x2 onto 2x2): full-scale and
        // zero samples, ignored loads outside the source grid, corners, and
        // computes just past and far past the destination grid.
        load_at(0, 0, 16'hFFFF);
        load_at(1, 0, 16'h0000);
        load_at(0, 1, 16'h8000);
        load_at(1, 1, 16'h0001);
        load_at(2, 0, 16'h1234);
        load_at(16383, 16383, 16'hFFFF);
        compute_at(0, 0);
        compute_at(1, 1);
        compute_at(1, 0);
        compute_at(2, 0);
        compute_at(0, 2);
        compute_at(16383, 16383);

        // 3x3 onto 5x5 in byte mode: a half-way point between 0 and 1 must
        // round up to 1, a blend of large samples saturates to the byte limit,
        // and the last column and row use the far neighbour at full weight.
        apply_setting(3, 3, 5, 5, 1);
        load_at(0, 0, 0);
        load_at(1, 0, 1);
        load_at(0, 1, 16'hFFFF);
        load_at(1, 1, 16'hFFFF);
        compute_at(1, 0);
        compute_at(1, 1);
        compute_at(4, 4);
        compute_at(4, 0);
        compute_at(2, 3);
        compute_at(5, 0);
        compute_at(0, 5);

        // Random part over several settings, extremes included: sizes below
        // two and above the maximum are clamped by the block.
        apply_setting(0, 1, 3, 2, 0);
        random_phase(40, 20);
        apply_setting(256, 256, 16384, 16384, 0);
        random_phase(40, -1);
        apply_setting(511, 2, 32767, 5, 1);
        quiet = 1'b1;
        random_phase(40, -1);
        quiet = 1'b0;
        apply_setting(2, 256, 2, 16384, 1);
        random_phase(40, 20);
        apply_setting(256, 3, 9, 700, 0);
        random_phase(40, -1);
        for (int p = 0; p < 5; p++) begin
            apply_setting($urandom_range(2, 20), $urandom_range(2, 20),
                          $urandom_range(2, 64), $urandom_range(2, 64),
                          $urandom_range(0, 1));
            quiet = ($urandom_range(0, 3) == 0);
            random_phase(40, $urandom_range(0, 39));
        end
        quiet = 1'b0;
        apply_setting(1, 0, 1, 0, 1);
        random_phase(35, -1);

        // Let every result come back, then a last quiet stretch.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bgu_pkg.sv
rtl/core/bgu_regs.sv
rtl/core/bgu_store.sv
rtl/core/bgu_div.sv
rtl/core/bilinear_grid_upscaler.sv
tb/sv/bilinear_grid_upscaler_checker.sv
tb/sv/bilinear_grid_upscaler_test.sv
